// ===== rtl/lzw_trie_compressor_macros.svh =====
// ----------------------------------------------------------------------------
// LZW trie compressor assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LZW_TRIE_COMPRESSOR_MACROS_SVH
`define LZW_TRIE_COMPRESSOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Types and constants shared by the LZW trie compressor files.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 8'd16;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 2'd1;

    localparam logic CAUSE_FULL  = 1'b0;
    localparam logic CAUSE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_CODE  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EMIT_HIT,
        S_MISS,
        S_LINK,
        S_EMIT_MISS,
        S_LASTCHK,
        S_FLUSH,
        S_DONE,
        S_FIN
    } t_state;

endpackage

// ===== rtl/ltc_ram.sv =====
// ----------------------------------------------------------------------------
// ltc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ltc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lzw_trie_compressor.sv =====
// Flow: an item is accepted in idle and walks the trie node by node; each miss adds an entry, links it,
//   emits a code and starts a fresh walk; depth-hit codes, flush and frame done are pushed in their own states.
//   A byte of a failed frame goes straight from idle to the finish state. A blocked result stream stalls every push.
// Throughput: one item at a time; the sibling walk through the trie RAM read port sets it.
// Reset: synchronous, active low; clears frame state, registers to 65535 and 16.
//   The trie RAM is not cleared: every node is written whole when allocated.
// ----------------------------------------------------------------------------
// lzw_trie_compressor
// LZW compressor walking a first-child/next-sibling trie held in one RAM.
// ----------------------------------------------------------------------------
module lzw_trie_compressor #(
    parameter int DICT_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [ltc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ltc_pkg::CFG_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // byte_value
    input  logic                            s_axis_tlast,   // last_byte
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // code, entry_index, entry_prefix, entry_value, error_cause, code_count, zero pad
    output logic [((2*($clog2(DICT_ENTRIES)+1)+$clog2(DICT_ENTRIES)+25)+7)/8*8-1:0]
                                            m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,   // kind
    output logic                            m_axis_tlast    // last_result
);

    import ltc_pkg::*;

    localparam int AW     = $clog2(DICT_ENTRIES);
    localparam int NW     = AW + 1;
    localparam int NODE_W = BYTE_W + 2*NW;
    localparam int DW     = ((2*NW + AW + 25) + 7) / 8 * 8;
    localparam logic [NW-1:0] NONE = NW'(DICT_ENTRIES);

    // control state
    t_state             r_state, n_state;
    logic               r_last, n_last;
    logic [NW-1:0]      r_cur, n_cur;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [NW-1:0]      r_used, n_used;
    logic [NW-1:0]      r_root_child, n_root_child;
    logic [COUNT_W-1:0] r_codes, n_codes;
    logic               r_failed, n_failed;
    logic [1:0]         r_pass, n_pass;
    logic [COUNT_W-1:0] r_limit, n_limit;
    logic [DEPTH_W-1:0] r_maxd, n_maxd;
    logic               r_pend_v, n_pend_v;
    logic               r_out_v, n_out_v;

    // payload
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic [NW-1:0]      r_p, n_p;
    logic [NW-1:0]      r_tail, n_tail;
    logic [NODE_W-1:0]  r_tail_word, n_tail_word;
    logic [NODE_W-1:0]  r_cur_word, n_cur_word;
    logic [DW-1:0]      r_pend_data, n_pend_data;
    t_kind              r_pend_kind, n_pend_kind;
    logic [DW-1:0]      r_out_data, n_out_data;
    t_kind              r_out_kind, n_out_kind;
    logic               r_out_last, n_out_last;

    // trie RAM
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [NODE_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;

    logic [BYTE_W-1:0]  rd_val;
    logic [NW-1:0]      rd_sib;
    logic [NW-1:0]      start_ptr;
    logic [NW-1:0]      new_idx;
    logic               in_acc;
    logic               out_free;
    logic               push_ok;
    logic               limit_hit;
    logic               dict_full;
    logic               hit;
    logic               push;
    t_kind              push_kind;
    logic [DW-1:0]      push_data;
    logic               fin_move;

    function automatic logic [DW-1:0] pack(
        input logic [NW-1:0]      code,
        input logic [AW-1:0]      idx,
        input logic [NW-1:0]      pre,
        input logic [BYTE_W-1:0]  val,
        input logic               cause,
        input logic [COUNT_W-1:0] count
    );
        pack = DW'({count, cause, val, pre, idx, code});
    endfunction

    ltc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DICT_ENTRIES)
    ) u_trie (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // node word: {sibling, first child, byte}
    assign rd_val    = ram_rdata[BYTE_W-1:0];
    assign rd_sib    = ram_rdata[BYTE_W+NW +: NW];
    assign start_ptr = (r_cur == NONE) ? r_root_child : r_cur_word[BYTE_W +: NW];
    assign new_idx   = r_used - NW'(1);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_v || m_axis_tready;
    assign push_ok   = !r_pend_v || out_free;
    assign limit_hit = r_codes >= r_limit;
    assign dict_full = r_used == NONE;
    assign hit       = rd_val == r_byte;

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = r_failed ? S_FIN : S_START;
                end
            end
            S_START: begin
                n_state = (start_ptr == NONE) ? S_MISS : S_READ;
            end
            S_READ: begin
                if (hit) begin
                    n_state = (r_depth + DEPTH_W'(1) == r_maxd) ? S_EMIT_HIT : S_LASTCHK;
                end else if (rd_sib == NONE) begin
                    n_state = S_MISS;
                end
            end
            S_EMIT_HIT: begin
                if (push_ok) begin
                    n_state = limit_hit ? S_FIN : S_LASTCHK;
                end
            end
            S_MISS: begin
                if (push_ok) begin
                    n_state = dict_full ? S_FIN : S_LINK;
                end
            end
            S_LINK: begin
                n_state = S_EMIT_MISS;
            end
            S_EMIT_MISS: begin
                if (push_ok) begin
                    if (limit_hit) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = (r_pass == 2'd2) ? S_LASTCHK : S_START;
                    end
                end
            end
            S_LASTCHK: begin
                if (!r_last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = (r_cur != NONE) ? S_FLUSH : S_DONE;
                end
            end
            S_FLUSH: begin
                if (push_ok) begin
                    n_state = limit_hit ? S_FIN : S_DONE;
                end
            end
            S_DONE: begin
                if (push_ok) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_last       = r_last;
        n_cur        = r_cur;
        n_depth      = r_depth;
        n_used       = r_used;
        n_root_child = r_root_child;
        n_codes      = r_codes;
        n_failed     = r_failed;
        n_pass       = r_pass;
        n_limit      = r_limit;
        n_maxd       = r_maxd;
        n_byte       = r_byte;
        n_p          = r_p;
        n_tail       = r_tail;
        n_tail_word  = r_tail_word;
        n_cur_word   = r_cur_word;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        push         = 1'b0;
        push_kind    = KIND_CODE;
        push_data    = '0;
        fin_move     = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OUTPUT_LIMIT: n_limit = i_cfg_wdata;
                REG_MAX_DEPTH:    n_maxd  = i_cfg_wdata[DEPTH_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_byte = s_axis_tdata;
                    n_last = s_axis_tlast;
                    n_pass = 2'd0;
                end
            end
            S_START: begin
                n_tail    = NONE;
                n_p       = start_ptr;
                ram_raddr = start_ptr[AW-1:0];
            end
            S_READ: begin
                if (hit) begin
                    n_cur      = r_p;
                    n_cur_word = ram_rdata;
                    n_depth    = r_depth + DEPTH_W'(1);
                end else begin
                    // advance along the sibling list
                    n_tail      = r_p;
                    n_tail_word = ram_rdata;
                    n_p         = rd_sib;
                    ram_raddr   = rd_sib[AW-1:0];
                end
            end
            S_EMIT_HIT, S_EMIT_MISS, S_FLUSH: begin
                if (push_ok) begin
                    push = 1'b1;
                    if (limit_hit) begin
                        push_kind = KIND_ERROR;
                        push_data = pack('0, '0, '0, '0, CAUSE_LIMIT, '0);
                        n_failed  = 1'b1;
                    end else begin
                        push_kind = KIND_CODE;
                        push_data = pack(r_cur, '0, '0, '0, 1'b0, '0);
                        n_codes   = r_codes + COUNT_W'(1);
                        n_cur     = NONE;
                        n_depth   = '0;
                        if (r_state == S_EMIT_MISS) begin
                            n_pass = r_pass + 2'd1;
                        end
                    end
                end
            end
            S_MISS: begin
                if (push_ok) begin
                    push = 1'b1;
                    if (dict_full) begin
                        push_kind = KIND_ERROR;
                        push_data = pack('0, '0, '0, '0, CAUSE_FULL, '0);
                        n_failed  = 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_used[AW-1:0];
                        ram_wdata = {NONE, NONE, r_byte};
                        push_kind = KIND_ENTRY;
                        push_data = pack('0, r_used[AW-1:0], r_cur, r_byte, 1'b0, '0);
                        n_used    = r_used + NW'(1);
                    end
                end
            end
            S_LINK: begin
                // hang the new node off the list tail, the parent, or the root
                if (r_tail != NONE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_tail[AW-1:0];
                    ram_wdata = {new_idx, r_tail_word[BYTE_W +: NW], r_tail_word[BYTE_W-1:0]};
                end else if (r_cur != NONE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur[AW-1:0];
                    ram_wdata = {r_cur_word[BYTE_W+NW +: NW], new_idx,
                                 r_cur_word[BYTE_W-1:0]};
                end else begin
                    n_root_child = new_idx;
                end
            end
            S_DONE: begin
                if (push_ok) begin
                    push      = 1'b1;
                    push_kind = KIND_DONE;
                    push_data = pack('0, '0, '0, '0, 1'b0, r_codes);
                end
            end
            S_FIN: begin
                if (!r_pend_v || out_free) begin
                    fin_move = 1'b1;
                    if (r_last) begin
                        n_root_child = NONE;
                        n_used       = '0;
                        n_cur        = NONE;
                        n_depth      = '0;
                        n_codes      = '0;
                        n_failed     = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // hold one result back so the last of an item can be marked
    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_data = r_pend_data;
        n_pend_kind = r_pend_kind;
        n_out_v     = r_out_v;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;

        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end
        if (push) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_data = r_pend_data;
                n_out_kind = r_pend_kind;
                n_out_last = 1'b0;
            end
            n_pend_v    = 1'b1;
            n_pend_data = push_data;
            n_pend_kind = push_kind;
        end
        if (fin_move && r_pend_v) begin
            n_out_v    = 1'b1;
            n_out_data = r_pend_data;
            n_out_kind = r_pend_kind;
            n_out_last = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last       <= 1'b0;
            r_cur        <= NONE;
            r_depth      <= '0;
            r_used       <= '0;
            r_root_child <= NONE;
            r_codes      <= '0;
            r_failed     <= 1'b0;
            r_pass       <= 2'd0;
            r_limit      <= LIMIT_RESET;
            r_maxd       <= DEPTH_RESET;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last       <= n_last;
            r_cur        <= n_cur;
            r_depth      <= n_depth;
            r_used       <= n_used;
            r_root_child <= n_root_child;
            r_codes      <= n_codes;
            r_failed     <= n_failed;
            r_pass       <= n_pass;
            r_limit      <= n_limit;
            r_maxd       <= n_maxd;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_p         <= n_p;
        r_tail      <= n_tail;
        r_tail_word <= n_tail_word;
        r_cur_word  <= n_cur_word;
        r_pend_data <= n_pend_data;
        r_pend_kind <= n_pend_kind;
        r_out_data  <= n_out_data;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
    end

endmodule

// ===== rtl/ltc_checker.sv =====
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks on the result stream of the LZW trie compressor.
// ----------------------------------------------------------------------------
`include "lzw_trie_compressor_macros.svh"

module ltc_checker #(
    parameter int DATA_W = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser,
    input logic              m_axis_tlast
);

    import ltc_pkg::*;

    // a stalled word holds
    `LTC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled word changed")

    // errors and frame done end the results of an item
    `LTC_ASSERT_NOW(a_end_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ERROR || m_axis_tuser == KIND_DONE), m_axis_tlast, "error or done word without tlast")

    // a new entry is always followed by its code or an error
    `LTC_ASSERT_NOW(a_entry_not_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_ENTRY, !m_axis_tlast, "entry word marked last")

    `LTC_ASSERT_NEXT(a_entry_no_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ENTRY, !(m_axis_tvalid && m_axis_tuser == KIND_DONE), "done word straight after an entry")

endmodule

bind lzw_trie_compressor ltc_checker #(
    .DATA_W ($bits(m_axis_tdata))
) u_ltc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
